// ===== hw/rtl/bba_pkg.sv =====
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int MAX_ORDER_DEF  = 10;

    localparam int REQ_W  = 11;
    localparam int BLK_W  = 10;
    localparam int ORD_W  = 4;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 11;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 16;
    localparam int ROW_W  = 32;
    localparam int ROW_SH = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CHECK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SPLIT_RD,
        ST_SPLIT_WR,
        ST_BUD_RD,
        ST_BUD_CHK,
        ST_SET_RD,
        ST_SET_WR,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        RES_ALLOC,
        RES_FREE,
        RES_ZERO,
        RES_FAIL
    } t_res;

    typedef enum logic [1:0] {
        ADDR_SCAN,
        ADDR_SPLIT,
        ADDR_BUD,
        ADDR_SELF
    } t_addr_sel;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_INIT,
        WR_CLR_SCAN,
        WR_SET,
        WR_CLR_BUD
    } t_wr_sel;

    typedef struct packed {
        logic      load;
        logic      setup;
        logic      rd;
        t_addr_sel asel;
        t_wr_sel   wsel;
        logic      row_inc;
        logic      ord_inc;
        logic      hit;
        logic      split_dec;
        logic      split_adv;
        logic      merge;
        logic      res_load;
        t_res      res;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic out_free;
        logic kind;
        logic zero_req;
        logic too_big;
        logic bad_free;
        logic row_hit;
        logic last_row;
        logic k_at_top;
        logic k_gt_m;
        logic bud_free;
    } t_stat;

    function automatic logic [ORD_W-1:0] flog2(input logic [REQ_W-1:0] v);
        logic [ORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < REQ_W; i++) begin
            if (v[i]) begin
                r = ORD_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bba_ctrl.sv =====
module bba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_cfg_wr_en,
    input  bba_pkg::t_stat i_stat,
    output logic          o_ready,
    output bba_pkg::t_cmd o_cmd
);

    bba_pkg::t_state r_state, n_state;
    bba_pkg::t_res   r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::ST_INIT;
            r_res   <= bba_pkg::RES_FAIL;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.res = r_res;
        case (r_state)
            bba_pkg::ST_INIT: begin
                o_cmd.wsel = bba_pkg::WR_INIT;
                if (i_stat.init_last) begin
                    n_state = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bba_pkg::ST_DECODE;
                end
            end
            bba_pkg::ST_DECODE: begin
                o_cmd.setup = 1'b1;
                n_state     = bba_pkg::ST_CHECK;
            end
            bba_pkg::ST_CHECK: begin
                if (i_stat.zero_req) begin
                    n_res   = bba_pkg::RES_ZERO;
                    n_state = bba_pkg::ST_RESULT;
                end else if (i_stat.too_big) begin
                    n_res   = bba_pkg::RES_FAIL;
                    n_state = bba_pkg::ST_RESULT;
                end else if (i_stat.kind == bba_pkg::KIND_ALLOC) begin
                    n_state = bba_pkg::ST_SCAN_RD;
                end else if (i_stat.bad_free) begin
                    n_res   = bba_pkg::RES_FAIL;
                    n_state = bba_pkg::ST_RESULT;
                end else begin
                    n_state = bba_pkg::ST_BUD_RD;
                end
            end
            bba_pkg::ST_SCAN_RD: begin
                o_cmd.rd   = 1'b1;
                o_cmd.asel = bba_pkg::ADDR_SCAN;
                n_state    = bba_pkg::ST_SCAN_CHK;
            end
            bba_pkg::ST_SCAN_CHK: begin
                if (i_stat.row_hit) begin
                    o_cmd.wsel = bba_pkg::WR_CLR_SCAN;
                    o_cmd.hit  = 1'b1;
                    n_state    = bba_pkg::ST_SPLIT_RD;
                end else if (!i_stat.last_row) begin
                    o_cmd.row_inc = 1'b1;
                    n_state       = bba_pkg::ST_SCAN_RD;
                end else if (!i_stat.k_at_top) begin
                    o_cmd.ord_inc = 1'b1;
                    n_state       = bba_pkg::ST_SCAN_RD;
                end else begin
                    n_res   = bba_pkg::RES_FAIL;
                    n_state = bba_pkg::ST_RESULT;
                end
            end
            bba_pkg::ST_SPLIT_RD: begin
                if (i_stat.k_gt_m) begin
                    o_cmd.rd        = 1'b1;
                    o_cmd.asel      = bba_pkg::ADDR_SPLIT;
                    o_cmd.split_dec = 1'b1;
                    n_state         = bba_pkg::ST_SPLIT_WR;
                end else begin
                    n_res   = bba_pkg::RES_ALLOC;
                    n_state = bba_pkg::ST_RESULT;
                end
            end
            bba_pkg::ST_SPLIT_WR: begin
                o_cmd.wsel      = bba_pkg::WR_SET;
                o_cmd.split_adv = 1'b1;
                n_state         = bba_pkg::ST_SPLIT_RD;
            end
            bba_pkg::ST_BUD_RD: begin
                if (!i_stat.k_at_top) begin
                    o_cmd.rd   = 1'b1;
                    o_cmd.asel = bba_pkg::ADDR_BUD;
                    n_state    = bba_pkg::ST_BUD_CHK;
                end else begin
                    n_state = bba_pkg::ST_SET_RD;
                end
            end
            bba_pkg::ST_BUD_CHK: begin
                if (i_stat.bud_free) begin
                    o_cmd.wsel  = bba_pkg::WR_CLR_BUD;
                    o_cmd.merge = 1'b1;
                    n_state     = bba_pkg::ST_BUD_RD;
                end else begin
                    n_state = bba_pkg::ST_SET_RD;
                end
            end
            bba_pkg::ST_SET_RD: begin
                o_cmd.rd   = 1'b1;
                o_cmd.asel = bba_pkg::ADDR_SELF;
                n_state    = bba_pkg::ST_SET_WR;
            end
            bba_pkg::ST_SET_WR: begin
                o_cmd.wsel = bba_pkg::WR_SET;
                n_res      = bba_pkg::RES_FREE;
                n_state    = bba_pkg::ST_RESULT;
            end
            bba_pkg::ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = bba_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::ST_INIT;
            end
        endcase
        if (i_cfg_wr_en) begin
            n_state = bba_pkg::ST_INIT;
        end
    end

endmodule

// ===== hw/rtl/bba_dpath.sv =====
module bba_dpath #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_ORDER  = bba_pkg::MAX_ORDER_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [bba_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic                         i_kind,
    input  logic [bba_pkg::REQ_W-1:0]    i_req,
    input  logic [bba_pkg::BLK_W-1:0]    i_blk,
    input  bba_pkg::t_cmd                i_cmd,
    input  logic                         i_out_ready,
    output bba_pkg::t_stat               o_stat,
    output logic                         o_out_valid,
    output logic [bba_pkg::OUT_W-1:0]    o_out_data
);

    localparam int EFF   = (NUM_BLOCKS < 2048) ? NUM_BLOCKS : 2048;
    localparam int AW    = $clog2(EFF);
    localparam int MAXO  = (MAX_ORDER < AW) ? MAX_ORDER : AW;
    localparam int NORD  = MAXO + 1;
    localparam int KW    = $clog2(NORD);
    localparam int RW    = (AW > bba_pkg::ROW_SH) ? AW - bba_pkg::ROW_SH : 1;
    localparam int ADW   = KW + RW;
    localparam int DEPTH = NORD << RW;
    localparam int JW    = RW + bba_pkg::ROW_SH;
    localparam int OW    = bba_pkg::ORD_W;

    logic [bba_pkg::ROW_W-1:0] mem [DEPTH];

    logic [bba_pkg::CFG_W-1:0] r_total;
    logic [OW-1:0]             r_top;
    logic [ADW-1:0]            r_icnt;
    logic                      r_kind;
    logic [bba_pkg::REQ_W-1:0] r_req;
    logic [bba_pkg::BLK_W-1:0] r_blk;
    logic [OW-1:0]             r_m;
    logic [OW-1:0]             r_k;
    logic [RW-1:0]             r_row;
    logic [AW-1:0]             r_b;
    logic [ADW-1:0]            r_raddr;
    logic [bba_pkg::ROW_W-1:0] r_rdata;
    logic                      r_out_valid;
    logic [bba_pkg::OUT_W-1:0] r_out_data;

    logic [bba_pkg::CFG_W-1:0] pool;
    logic [OW-1:0]             fl_pool;
    logic [bba_pkg::REQ_W-1:0] reqm1;
    logic [OW-1:0]             m_calc;
    logic [AW-1:0]             bud;
    logic [AW-1:0]             j_self;
    logic [AW-1:0]             j_bud;
    logic [AW-1:0]             j_split;
    logic [4:0]                lowbit;
    logic [ADW-1:0]            rd_addr;
    logic                      we;
    logic [ADW-1:0]            waddr;
    logic [bba_pkg::ROW_W-1:0] wdata;
    logic [bba_pkg::ROW_W-1:0] init_word;
    logic [KW-1:0]             ik;
    logic [11:0]               cnt_i;
    logic [11:0]               cnt_k;
    logic [11:0]               last_row;
    logic [11:0]               size12;
    logic [11:0]               blk12;

    function automatic logic [ADW-1:0] addr_of(input logic [OW-1:0] k, input logic [AW-1:0] j);
        return {KW'(k), RW'(j >> bba_pkg::ROW_SH)};
    endfunction

    assign pool    = (32'(r_total) < NUM_BLOCKS) ? r_total : bba_pkg::CFG_W'(NUM_BLOCKS);
    assign fl_pool = bba_pkg::flog2(pool);
    assign reqm1   = r_req - 11'd1;
    assign m_calc  = (r_req <= 11'd1) ? '0 : bba_pkg::flog2(reqm1) + 4'd1;
    assign bud     = r_b ^ (AW'(1) << r_k);
    assign j_self  = r_b >> r_k;
    assign j_bud   = bud >> r_k;
    assign j_split = r_b >> (r_k - 4'd1);
    assign ik      = r_icnt[ADW-1:RW];
    assign cnt_i   = 12'(pool) >> ik;
    assign cnt_k   = 12'(pool) >> r_k;
    assign last_row = (cnt_k == 12'd0) ? 12'd0 : (cnt_k - 12'd1) >> bba_pkg::ROW_SH;
    assign size12  = 12'd1 << r_m;
    assign blk12   = 12'(r_blk);

    always_comb begin
        lowbit = '0;
        for (int x = bba_pkg::ROW_W - 1; x >= 0; x--) begin
            if (r_rdata[x]) begin
                lowbit = 5'(x);
            end
        end
    end

    always_comb begin
        logic [11:0] j12;
        init_word = '0;
        for (int x = 0; x < bba_pkg::ROW_W; x++) begin
            j12 = 12'({r_icnt[RW-1:0], 5'(x)});
            if (ik == KW'(MAXO)) begin
                init_word[x] = (j12 < cnt_i);
            end else begin
                init_word[x] = cnt_i[0] && (j12 == {cnt_i[11:1], 1'b0});
            end
        end
    end

    always_comb begin
        case (i_cmd.asel)
            bba_pkg::ADDR_SCAN:  rd_addr = {KW'(r_k), r_row};
            bba_pkg::ADDR_SPLIT: rd_addr = addr_of(r_k - 4'd1, j_split);
            bba_pkg::ADDR_BUD:   rd_addr = addr_of(r_k, j_bud);
            default:             rd_addr = addr_of(r_k, j_self);
        endcase
    end

    always_comb begin
        we    = 1'b1;
        waddr = r_raddr;
        case (i_cmd.wsel)
            bba_pkg::WR_INIT: begin
                waddr = r_icnt;
                wdata = init_word;
            end
            bba_pkg::WR_CLR_SCAN: wdata = r_rdata & ~(32'd1 << lowbit);
            bba_pkg::WR_SET:      wdata = r_rdata | (32'd1 << 5'(j_self));
            bba_pkg::WR_CLR_BUD:  wdata = r_rdata & ~(32'd1 << 5'(j_bud));
            default: begin
                we    = 1'b0;
                wdata = r_rdata;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= bba_pkg::CFG_RESET;
            r_icnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_total <= i_cfg_wr_data;
                r_icnt  <= '0;
            end else if (i_cmd.wsel == bba_pkg::WR_INIT) begin
                r_icnt <= r_icnt + ADW'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= (fl_pool > OW'(MAXO)) ? OW'(MAXO) : fl_pool;
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_req  <= i_req;
            r_blk  <= i_blk;
        end
        if (i_cmd.rd) begin
            r_raddr <= rd_addr;
        end
        if (i_cmd.setup) begin
            r_m   <= m_calc;
            r_k   <= m_calc;
            r_row <= '0;
            r_b   <= AW'(blk12);
        end
        if (i_cmd.row_inc) begin
            r_row <= r_row + RW'(1);
        end
        if (i_cmd.ord_inc) begin
            r_k   <= r_k + 4'd1;
            r_row <= '0;
        end
        if (i_cmd.hit) begin
            r_b <= AW'(JW'({r_row, lowbit}) << r_k);
        end
        if (i_cmd.split_dec) begin
            r_k <= r_k - 4'd1;
        end
        if (i_cmd.split_adv) begin
            r_b <= r_b + (AW'(1) << r_k);
        end
        if (i_cmd.merge) begin
            r_b <= (bud < r_b) ? bud : r_b;
            r_k <= r_k + 4'd1;
        end
        if (i_cmd.res_load) begin
            case (i_cmd.res)
                bba_pkg::RES_ALLOC: r_out_data <= {r_m, 10'(r_b), bba_pkg::STAT_OK};
                bba_pkg::RES_FREE:  r_out_data <= {14'd0, bba_pkg::STAT_OK};
                bba_pkg::RES_ZERO:  r_out_data <= {14'd0, bba_pkg::STAT_ZERO};
                default:            r_out_data <= {14'd0, bba_pkg::STAT_NOSPACE};
            endcase
        end
    end

    always_comb begin
        o_stat.init_last = (r_icnt == ADW'(DEPTH - 1));
        o_stat.out_free  = !r_out_valid || i_out_ready;
        o_stat.kind      = r_kind;
        o_stat.zero_req  = (r_req == '0);
        o_stat.too_big   = (r_m > r_top);
        o_stat.bad_free  = ((blk12 & (size12 - 12'd1)) != 12'd0) || ((blk12 + size12) > 12'(pool));
        o_stat.row_hit   = |r_rdata;
        o_stat.last_row  = (r_row == RW'(last_row));
        o_stat.k_at_top  = (r_k == r_top);
        o_stat.k_gt_m    = (r_k > r_m);
        o_stat.bud_free  = r_rdata[5'(j_bud)];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hw/rtl/buddy_block_allocator.sv =====
// Binary buddy allocator over a pool of equal blocks.
// Input items arrive on the s_axis channel: tuser is the operation (0 allocate,
// 1 free) and tdata carries the size in blocks and, for a free, the first block.
// One result item per input item leaves on the m_axis channel with a status,
// the first block granted and the order of the chunk granted.
// The pool size is set through the configuration write port; a write rebuilds
// the free map, and the block accepts no item during that pass.
// The free map sits in one memory of 32-bit rows, one row region per order, and
// a single read and write port serves every step. An item is accepted, then
// decoded and checked; an allocation then scans rows in turn (one row for an
// empty order) and splits the found chunk step by step, while a free tries a
// merge with its buddy at each order until one fails or merging reaches the
// top order, then marks the chunk; last the result is loaded. A zero-size
// item, or one rejected at the check, goes straight to the result; a single-block
// request on the fresh default pool scans 68 rows and splits 10 times.
// After reset, and after each configuration write, a rebuild pass writes every
// row, one a cycle (352 rows with the defaults). A finished result waits in an
// output register while the receiver stalls; the next item may be accepted
// meanwhile, and its result is held back until the register is free.
module buddy_block_allocator #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_ORDER  = bba_pkg::MAX_ORDER_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [bba_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [bba_pkg::IN_W-1:0]  s_axis_tdata,  // request_blocks, block_index, zeros
    input  logic [0:0]                s_axis_tuser,  // kind
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [bba_pkg::OUT_W-1:0] m_axis_tdata   // status, granted_index, granted_order
);

    bba_pkg::t_cmd  cmd;
    bba_pkg::t_stat stat;

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_stat      (stat),
        .o_ready     (s_axis_tready),
        .o_cmd       (cmd)
    );

    bba_dpath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .MAX_ORDER  (MAX_ORDER)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_kind        (s_axis_tuser[0]),
        .i_req         (s_axis_tdata[10:0]),
        .i_blk         (s_axis_tdata[20:11]),
        .i_cmd         (cmd),
        .i_out_ready   (m_axis_tready),
        .o_stat        (stat),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata)
    );

endmodule

// ===== hw/rtl/bba_checker.sv =====
module bba_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_wr_en,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [bba_pkg::OUT_W-1:0] m_axis_tdata
);

    // The rebuild pass after reset keeps the input closed.
    a_reset_closes: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready straight after reset");

    // Only one item is worked on at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) || i_cfg_wr_en |=> !s_axis_tready)
        else $error("input ready in the cycle after an accept or a rebuild");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A failed or zero-size item grants nothing.
    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != bba_pkg::STAT_OK |->
            m_axis_tdata[15:2] == 14'd0 && m_axis_tdata[1:0] != 2'd3)
        else $error("bad status or grant on a failed result");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);

// ===== tb/sv/tb_top.sv =====
module tb_top;

    localparam logic KIND_FREE = ~bba_pkg::KIND_ALLOC;
    localparam int MAP_BITS = 2 * bba_pkg::NUM_BLOCKS_DEF;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int RANDOM_PER_PHASE = 170;

    typedef struct {
        logic                      kind;
        logic [bba_pkg::REQ_W-1:0] req;
        logic [bba_pkg::BLK_W-1:0] idx;
    } t_op;

    typedef struct {
        logic                       kind;
        logic [bba_pkg::STAT_W-1:0] status;
        logic [bba_pkg::BLK_W-1:0]  gidx;
        logic [bba_pkg::ORD_W-1:0]  gord;
    } t_grant;

    typedef struct {
        logic [bba_pkg::BLK_W-1:0] idx;
        int                        ord;
    } t_chunk;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic [bba_pkg::CFG_W-1:0]  i_cfg_wr_data = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [bba_pkg::IN_W-1:0]   s_axis_tdata = '0;
    logic [0:0]                 s_axis_tuser = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [bba_pkg::OUT_W-1:0]  m_axis_tdata;

    buddy_block_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    t_op    pending_ops[$];
    t_grant expected_grants[$];
    t_chunk live_chunks[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     error_count = 0;
    int     checked_count = 0;
    int     alloc_ok_count = 0;
    int     free_ok_count = 0;
    int     fail_count = 0;
    int     cycle_count = 0;

    bit          free_bits[MAP_BITS];
    int unsigned order_base[bba_pkg::MAX_ORDER_DEF + 1];
    int unsigned pool_blocks;
    int unsigned top_ord;

    function automatic int unsigned log2_floor(int unsigned v);
        int unsigned r;
        r = 0;
        while (v > 1) begin
            v = v >> 1;
            r++;
        end
        return r;
    endfunction

    function automatic bit bit_get(int unsigned k, int unsigned b);
        int unsigned i;
        if (k > bba_pkg::MAX_ORDER_DEF) begin
            return 1'b0;
        end
        i = order_base[k] + (b >> k);
        return (i < MAP_BITS) ? free_bits[i] : 1'b0;
    endfunction

    function automatic void bit_put(int unsigned k, int unsigned b, bit v);
        int unsigned i;
        if (k > bba_pkg::MAX_ORDER_DEF) begin
            return;
        end
        i = order_base[k] + (b >> k);
        if (i < MAP_BITS) begin
            free_bits[i] = v;
        end
    endfunction

    function automatic void rebuild_pool(int unsigned total);
        int unsigned acc, rem, pos, k;
        acc = 0;
        for (int o = 0; o <= bba_pkg::MAX_ORDER_DEF; o++) begin
            order_base[o] = acc;
            acc += bba_pkg::NUM_BLOCKS_DEF >> o;
        end
        foreach (free_bits[i]) begin
            free_bits[i] = 1'b0;
        end
        pool_blocks = (total < bba_pkg::NUM_BLOCKS_DEF) ? total : bba_pkg::NUM_BLOCKS_DEF;
        top_ord = log2_floor(pool_blocks);
        if (top_ord > bba_pkg::MAX_ORDER_DEF) begin
            top_ord = bba_pkg::MAX_ORDER_DEF;
        end
        rem = pool_blocks;
        pos = 0;
        while (rem > 0) begin
            k = log2_floor(rem);
            if (k > bba_pkg::MAX_ORDER_DEF) begin
                k = bba_pkg::MAX_ORDER_DEF;
            end
            bit_put(k, pos, 1'b1);
            pos += 1 << k;
            rem -= 1 << k;
        end
        live_chunks.delete();
    endfunction

    function automatic t_grant predict_grant(t_op op);
        t_grant g;
        int unsigned m, k, b, bud, size;
        bit found;
        g.kind = op.kind;
        g.status = bba_pkg::STAT_OK;
        g.gidx = '0;
        g.gord = '0;
        if (op.req == 0) begin
            g.status = bba_pkg::STAT_ZERO;
            return g;
        end
        m = 0;
        while ((1 << m) < op.req) begin
            m++;
        end
        if (m > top_ord) begin
            g.status = bba_pkg::STAT_NOSPACE;
            return g;
        end
        if (op.kind == bba_pkg::KIND_ALLOC) begin
            found = 1'b0;
            b = 0;
            for (k = m; k <= top_ord; k++) begin
                for (int unsigned j = 0; j < (pool_blocks >> k); j++) begin
                    if (bit_get(k, j << k)) begin
                        b = j << k;
                        found = 1'b1;
                        break;
                    end
                end
                if (found) begin
                    break;
                end
            end
            if (!found) begin
                g.status = bba_pkg::STAT_NOSPACE;
                return g;
            end
            bit_put(k, b, 1'b0);
            while (k > m) begin
                k--;
                bit_put(k, b, 1'b1);
                b += 1 << k;
            end
            g.gidx = bba_pkg::BLK_W'(b);
            g.gord = bba_pkg::ORD_W'(m);
            live_chunks.push_back('{idx: bba_pkg::BLK_W'(b), ord: m});
        end else begin
            size = 1 << m;
            if ((op.idx & (size - 1)) != 0 || op.idx + size > pool_blocks) begin
                g.status = bba_pkg::STAT_NOSPACE;
                return g;
            end
            k = m;
            b = op.idx;
            while (k < top_ord) begin
                bud = b ^ (1 << k);
                if (!bit_get(k, bud)) begin
                    break;
                end
                bit_put(k, bud, 1'b0);
                if (bud < b) begin
                    b = bud;
                end
                k++;
            end
            bit_put(k, b, 1'b1);
        end
        return g;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("Mismatch at cycle %0d: %s got %0d, expected %0d",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_op op;
                op = pending_ops.pop_front();
                s_axis_tdata <= {{(bba_pkg::IN_W - bba_pkg::REQ_W - bba_pkg::BLK_W){1'b0}},
                                 op.idx, op.req};
                s_axis_tuser <= op.kind;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t_op op;
            op.req = s_axis_tdata[bba_pkg::REQ_W-1:0];
            op.idx = s_axis_tdata[bba_pkg::REQ_W+bba_pkg::BLK_W-1:bba_pkg::REQ_W];
            op.kind = s_axis_tuser[0];
            expected_grants.push_back(predict_grant(op));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_grant want;
            logic [bba_pkg::STAT_W-1:0] st;
            logic [bba_pkg::BLK_W-1:0]  gi;
            logic [bba_pkg::ORD_W-1:0]  go;
            st = m_axis_tdata[bba_pkg::STAT_W-1:0];
            gi = m_axis_tdata[bba_pkg::STAT_W+bba_pkg::BLK_W-1:bba_pkg::STAT_W];
            go = m_axis_tdata[bba_pkg::OUT_W-1:bba_pkg::STAT_W+bba_pkg::BLK_W];
            if (expected_grants.size() == 0) begin
                report_mismatch("unexpected item, status", st, 0);
            end else begin
                want = expected_grants.pop_front();
                checked_count++;
                if (st != want.status) report_mismatch("status", st, want.status);
                if (gi != want.gidx) report_mismatch("granted_index", gi, want.gidx);
                if (go != want.gord) report_mismatch("granted_order", go, want.gord);
                if (want.status != bba_pkg::STAT_OK) begin
                    fail_count++;
                end else if (want.kind == KIND_FREE) begin
                    free_ok_count++;
                end else begin
                    alloc_ok_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_op(logic kind, int unsigned req, int unsigned idx);
        pending_ops.push_back('{kind: kind, req: bba_pkg::REQ_W'(req),
                                idx: bba_pkg::BLK_W'(idx)});
    endtask

    task automatic wait_idle();
        while (pending_ops.size() > 0 || s_axis_tvalid || expected_grants.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_total(int unsigned value);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= bba_pkg::CFG_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        rebuild_pool(value & 11'h7FF);
    endtask

    task automatic push_random_op();
        int pick, n, o, hi;
        t_chunk c;
        pick = $urandom_range(99);
        if (pick < 10) begin
            push_op(1'($urandom_range(1)), $urandom_range(2047), $urandom_range(1023));
        end else if (pick < 55 && live_chunks.size() > 0) begin
            n = $urandom_range(live_chunks.size() - 1);
            c = live_chunks[n];
            live_chunks.delete(n);
            o = c.ord;
            hi = 1 << o;
            push_op(KIND_FREE, (o == 0) ? 1 : $urandom_range(hi, hi / 2 + 1), c.idx);
        end else begin
            o = $urandom_range(top_ord > 0 ? top_ord : 0);
            if ($urandom_range(3) != 0 && o > 4) begin
                o = $urandom_range(4);
            end
            push_op(bba_pkg::KIND_ALLOC, $urandom_range(1 << o, 1), $urandom_range(1023));
        end
    endtask

    initial begin
        int unsigned totals[7];
        totals = '{1024, 37, 1, 0, 2047, 1000, 512};
        rebuild_pool(bba_pkg::CFG_RESET);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_op(bba_pkg::KIND_ALLOC, 0, 0);
        push_op(KIND_FREE, 0, 1023);
        push_op(bba_pkg::KIND_ALLOC, 2047, 0);
        push_op(KIND_FREE, 1025, 0);
        push_op(bba_pkg::KIND_ALLOC, 1, 0);
        push_op(bba_pkg::KIND_ALLOC, 3, 0);
        push_op(bba_pkg::KIND_ALLOC, 1024, 0);
        push_op(bba_pkg::KIND_ALLOC, 512, 0);
        push_op(KIND_FREE, 1, 1023);
        push_op(KIND_FREE, 4, 2);
        push_op(KIND_FREE, 512, 768);
        push_op(KIND_FREE, 4, 1020);
        push_op(KIND_FREE, 1, 1023);
        push_op(KIND_FREE, 1024, 0);
        push_op(bba_pkg::KIND_ALLOC, 1024, 1023);
        push_op(KIND_FREE, 1024, 0);
        push_op(bba_pkg::KIND_ALLOC, 600, 0);
        push_op(KIND_FREE, 1024, 0);

        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                write_total(totals[p]);
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                while (pending_ops.size() > 1) begin
                    @(posedge i_clk);
                end
                push_random_op();
            end
        end
        wait_idle();

        $display("Checked %0d result items over seven pool sizes and four idling patterns.",
                 checked_count);
        $display("Allocations granted %0d, frees accepted %0d, rejections %0d.",
                 alloc_ok_count, free_ok_count, fail_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
